@@ rtl/lav_pkg.sv @@
`timescale 1ns / 1ps
package lav_pkg;

	localparam int COORD_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int AXIS_W    = 20;
	localparam int VEC_W     = 48;
	localparam int SCALE_TOP = 29;
	localparam int MAG_W     = SCALE_TOP + 1;
	localparam int QT_W      = FRAC_W + 1;
	localparam int NUM_W     = MAG_W + FRAC_W + 1;

	localparam logic signed [63:0] COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
	localparam logic signed [63:0] COORD_MIN = -(64'sd1 <<< (COORD_W - 1));
	localparam logic signed [COORD_W-1:0] COORD_ONE = COORD_W'(64'sd1 <<< FRAC_W);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [COORD_W:0]   diff_t;
	typedef logic signed [AXIS_W-1:0]  axis_t;

	// One accepted item: eye, eye minus target, up
	typedef struct packed {
		coord_t [2:0] eye;
		diff_t  [2:0] d;
		coord_t [2:0] up;
	} item_t;

	// Finished matrix: axes (x, y, z), translations, flag
	typedef struct packed {
		axis_t  [2:0][2:0] ax;
		coord_t [2:0]      trans;
		logic              degen;
	} solved_t;

endpackage

@@ rtl/lav_front.sv @@
`timescale 1ns / 1ps
module lav_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  lav_pkg::coord_t eye_x,
	input  lav_pkg::coord_t eye_y,
	input  lav_pkg::coord_t eye_z,
	input  lav_pkg::coord_t target_x,
	input  lav_pkg::coord_t target_y,
	input  lav_pkg::coord_t target_z,
	input  lav_pkg::coord_t up_x,
	input  lav_pkg::coord_t up_y,
	input  lav_pkg::coord_t up_z,
	output logic           q_valid,
	output lav_pkg::item_t q_item,
	input  logic           q_pop
);
	import lav_pkg::*;

	item_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	item_t      new_item;
	logic       push;

	// Form the difference vector at entry
	always_comb begin
		new_item.eye[0] = eye_x;
		new_item.eye[1] = eye_y;
		new_item.eye[2] = eye_z;
		new_item.d[0]   = diff_t'(eye_x) - diff_t'(target_x);
		new_item.d[1]   = diff_t'(eye_y) - diff_t'(target_y);
		new_item.d[2]   = diff_t'(eye_z) - diff_t'(target_z);
		new_item.up[0]  = up_x;
		new_item.up[1]  = up_y;
		new_item.up[2]  = up_z;
	end

	assign item_stall = (cnt_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign q_valid    = (cnt_q != 2'd0);
	assign q_item     = mem_q[rp_q];

	// Store a transfer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= new_item;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ rtl/lav_solver.sv @@
`timescale 1ns / 1ps
module lav_solver (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  lav_pkg::item_t   q_item,
	output logic             q_pop,
	output logic             sol_valid,
	output lav_pkg::solved_t sol,
	input  logic             sol_stall
);
	import lav_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE        = 8'b0000_0001,
		S_SCALE_P     = 8'b0000_0010,
		S_SCALE_APPLY = 8'b0000_0100,
		S_MAC         = 8'b0000_1000,
		S_SQRT        = 8'b0001_0000,
		S_DIV_INIT    = 8'b0010_0000,
		S_DIV         = 8'b0100_0000,
		S_DONE        = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {PASS_Z, PASS_UP, PASS_X} pass_t;
	typedef enum logic [1:0] {MODE_SQ, MODE_CR1, MODE_CR2, MODE_TR} mode_t;

	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

	state_t state_q;
	pass_t  pass_q;
	mode_t  mode_q;

	coord_t                   eye_q [3];
	coord_t                   up_q [3];
	logic signed [VEC_W-1:0]  vec_q [3];
	logic [5:0]               p_q;
	logic [MAG_W-1:0]         sc_mag_q [3];
	logic                     sc_neg_q [3];
	logic signed [MAG_W:0]    ups_q [3];
	axis_t                    ax_q [3][3];
	coord_t                   trans_q [3];
	logic                     degen_q;

	logic [63:0]              sq_n_q;
	logic [63:0]              sq_r_q;
	logic [63:0]              sq_bit_q;
	logic [MAG_W:0]           len_q;
	logic [4:0]               cnt_q;
	logic [1:0]               ci_q;
	logic [31:0]              rem_q;
	logic [QT_W-1:0]          lo_q;
	logic [QT_W-1:0]          qt_q;

	logic [1:0]               gi_q;
	logic [1:0]               ti_q;
	logic                     issued_q;
	logic signed [63:0]       mul_q;
	logic                     mv_q;
	logic                     m_neg_q;
	logic                     m_first_q;
	logic                     m_last_q;
	logic                     m_end_q;
	logic [1:0]               m_g_q;
	logic signed [63:0]       acc_q;

	logic [VEC_W-1:0]         vm [3];
	logic [VEC_W-1:0]         orv;
	logic [5:0]               p_c;
	logic [MAG_W-1:0]         shifted [3];
	coord_t                   opa;
	coord_t                   opb;
	logic                     op_neg;
	logic                     grp_last;
	logic                     all_last;
	logic signed [63:0]       sum_c;
	logic signed [63:0]       rnd_c;
	logic signed [63:0]       tn_c;
	coord_t                   tsat_c;
	logic [63:0]              sq_t;
	logic [63:0]              sq_r_next;
	logic [63:0]              sq_n_next;
	logic [NUM_W-1:0]         num_c;
	logic [31:0]              sh_c;
	logic                     ge_c;
	logic [QT_W-1:0]          q_c;
	axis_t                    qs_c;

	function automatic logic [1:0] rot1(input logic [1:0] g);
		case (g)
			2'd0:    rot1 = 2'd1;
			2'd1:    rot1 = 2'd2;
			default: rot1 = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] rot2(input logic [1:0] g);
		case (g)
			2'd0:    rot2 = 2'd2;
			2'd1:    rot2 = 2'd0;
			default: rot2 = 2'd1;
		endcase
	endfunction

	// Block scaling: find top bit of the OR of magnitudes, then shift
	always_comb begin
		orv = '0;
		for (int i = 0; i < 3; i++) begin
			vm[i] = vec_q[i][VEC_W-1] ? VEC_W'(-vec_q[i]) : VEC_W'(vec_q[i]);
			orv   = orv | vm[i];
		end
		p_c = '0;
		for (int b = 0; b < VEC_W; b++) begin
			if (orv[b]) p_c = 6'(b);
		end
		for (int i = 0; i < 3; i++) begin
			if (p_q > 6'(SCALE_TOP)) begin
				shifted[i] = MAG_W'(vm[i] >> (p_q - 6'(SCALE_TOP)));
			end else begin
				shifted[i] = MAG_W'(vm[i] << (6'(SCALE_TOP) - p_q));
			end
		end
	end

	// Select multiplier operands for the current term
	always_comb begin
		opa      = '0;
		opb      = '0;
		op_neg   = 1'b0;
		grp_last = (ti_q == 2'd2);
		case (mode_q)
			MODE_SQ: begin
				opa = $signed({{(COORD_W-MAG_W){1'b0}}, sc_mag_q[ti_q]});
				opb = opa;
			end
			MODE_CR1: begin
				opa      = COORD_W'(ups_q[ti_q[0] ? rot2(gi_q) : rot1(gi_q)]);
				opb      = COORD_W'(ax_q[AX_Z][ti_q[0] ? rot1(gi_q) : rot2(gi_q)]);
				op_neg   = ti_q[0];
				grp_last = ti_q[0];
			end
			MODE_CR2: begin
				opa      = COORD_W'(ax_q[AX_Z][ti_q[0] ? rot2(gi_q) : rot1(gi_q)]);
				opb      = COORD_W'(ax_q[AX_X][ti_q[0] ? rot1(gi_q) : rot2(gi_q)]);
				op_neg   = ti_q[0];
				grp_last = ti_q[0];
			end
			MODE_TR: begin
				opa = eye_q[ti_q];
				opb = COORD_W'(ax_q[gi_q][ti_q]);
			end
			default: begin
				opa = '0;
			end
		endcase
		all_last = grp_last && ((mode_q == MODE_SQ) || (gi_q == 2'd2));
	end

	// Accumulate, round and saturate
	always_comb begin
		sum_c = (m_first_q ? 64'sd0 : acc_q) + (m_neg_q ? -mul_q : mul_q);
		rnd_c = (sum_c + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
		tn_c  = (-sum_c + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
		if (tn_c > COORD_MAX) begin
			tsat_c = COORD_W'(COORD_MAX);
		end else if (tn_c < COORD_MIN) begin
			tsat_c = COORD_W'(COORD_MIN);
		end else begin
			tsat_c = COORD_W'(tn_c);
		end
	end

	// Square root step and division step
	always_comb begin
		sq_t = sq_r_q + sq_bit_q;
		if (sq_n_q >= sq_t) begin
			sq_n_next = sq_n_q - sq_t;
			sq_r_next = (sq_r_q >> 1) + sq_bit_q;
		end else begin
			sq_n_next = sq_n_q;
			sq_r_next = sq_r_q >> 1;
		end
		num_c = {1'b0, sc_mag_q[ci_q], {FRAC_W{1'b0}}} + NUM_W'(len_q >> 1);
		sh_c  = {rem_q[30:0], lo_q[QT_W-1]};
		ge_c  = (sh_c >= 32'(len_q));
		q_c   = {qt_q[QT_W-2:0], ge_c};
		qs_c  = sc_neg_q[ci_q] ? -AXIS_W'(q_c) : AXIS_W'(q_c);
	end

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign sol_valid = (state_q == S_DONE);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int i = 0; i < 3; i++) begin
				sol.ax[a][i] = ax_q[a][i];
			end
			sol.trans[a] = trans_q[a];
		end
		sol.degen = degen_q;
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				for (int i = 0; i < 3; i++) begin
					eye_q[i] <= q_item.eye[i];
					up_q[i]  <= q_item.up[i];
					vec_q[i] <= VEC_W'($signed(q_item.d[i]));
				end
			end
			S_SCALE_P: begin
				p_q <= p_c;
				if (orv == '0 && pass_q != PASS_UP) begin
					for (int i = 0; i < 3; i++) begin
						ax_q[(pass_q == PASS_Z) ? AX_Z : AX_X][i] <= '0;
					end
					if (pass_q == PASS_Z) begin
						for (int i = 0; i < 3; i++) vec_q[i] <= VEC_W'(up_q[i]);
					end
				end
			end
			S_SCALE_APPLY: begin
				for (int i = 0; i < 3; i++) begin
					sc_mag_q[i] <= shifted[i];
					sc_neg_q[i] <= vec_q[i][VEC_W-1];
					ups_q[i]    <= vec_q[i][VEC_W-1] ? -$signed({1'b0, shifted[i]})
						: $signed({1'b0, shifted[i]});
				end
			end
			S_MAC: begin
				if (!issued_q) begin
					mul_q     <= opa * opb;
					m_neg_q   <= op_neg;
					m_first_q <= (ti_q == 2'd0);
					m_last_q  <= grp_last;
					m_end_q   <= all_last;
					m_g_q     <= gi_q;
				end
				if (mv_q) begin
					acc_q <= sum_c;
					if (m_last_q) begin
						case (mode_q)
							MODE_SQ:  sq_n_q <= sum_c;
							MODE_CR1: vec_q[m_g_q] <= VEC_W'(sum_c);
							MODE_CR2: ax_q[AX_Y][m_g_q] <= AXIS_W'(rnd_c);
							MODE_TR:  trans_q[m_g_q] <= tsat_c;
							default:  acc_q <= sum_c;
						endcase
					end
					if (m_end_q && mode_q == MODE_SQ) begin
						sq_r_q   <= '0;
						sq_bit_q <= 64'd1 << 62;
					end
				end
			end
			S_SQRT: begin
				sq_n_q   <= sq_n_next;
				sq_r_q   <= sq_r_next;
				sq_bit_q <= sq_bit_q >> 2;
				if (cnt_q == 5'd31) len_q <= sq_r_next[MAG_W:0];
			end
			S_DIV_INIT: begin
				rem_q <= 32'(num_c[NUM_W-1:QT_W]);
				lo_q  <= num_c[QT_W-1:0];
				qt_q  <= '0;
			end
			S_DIV: begin
				rem_q <= ge_c ? sh_c - 32'(len_q) : sh_c;
				lo_q  <= lo_q << 1;
				qt_q  <= q_c;
				if (cnt_q == 5'(QT_W - 1)) begin
					ax_q[(pass_q == PASS_Z) ? AX_Z : AX_X][ci_q] <= qs_c;
					if (ci_q == 2'd2 && pass_q == PASS_Z) begin
						for (int i = 0; i < 3; i++) vec_q[i] <= VEC_W'(up_q[i]);
					end
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pass_q   <= PASS_Z;
			mode_q   <= MODE_SQ;
			degen_q  <= 1'b0;
			cnt_q    <= '0;
			ci_q     <= '0;
			gi_q     <= '0;
			ti_q     <= '0;
			issued_q <= 1'b0;
			mv_q     <= 1'b0;
		end else begin
			mv_q <= (state_q == S_MAC) && !issued_q;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						degen_q <= 1'b0;
						pass_q  <= PASS_Z;
						state_q <= S_SCALE_P;
					end
				end
				S_SCALE_P: begin
					if (orv == '0 && pass_q != PASS_UP) begin
						degen_q <= 1'b1;
						if (pass_q == PASS_Z) begin
							pass_q  <= PASS_UP;
							state_q <= S_SCALE_P;
						end else begin
							mode_q   <= MODE_CR2;
							gi_q     <= '0;
							ti_q     <= '0;
							issued_q <= 1'b0;
							state_q  <= S_MAC;
						end
					end else begin
						state_q <= S_SCALE_APPLY;
					end
				end
				S_SCALE_APPLY: begin
					mode_q   <= (pass_q == PASS_UP) ? MODE_CR1 : MODE_SQ;
					gi_q     <= '0;
					ti_q     <= '0;
					issued_q <= 1'b0;
					state_q  <= S_MAC;
				end
				S_MAC: begin
					if (!issued_q) begin
						if (grp_last) begin
							ti_q <= '0;
							gi_q <= gi_q + 2'd1;
						end else begin
							ti_q <= ti_q + 2'd1;
						end
						if (all_last) issued_q <= 1'b1;
					end
					if (mv_q && m_end_q) begin
						case (mode_q)
							MODE_SQ: begin
								cnt_q   <= '0;
								state_q <= S_SQRT;
							end
							MODE_CR1: begin
								pass_q  <= PASS_X;
								state_q <= S_SCALE_P;
							end
							MODE_CR2: begin
								mode_q   <= MODE_TR;
								gi_q     <= '0;
								ti_q     <= '0;
								issued_q <= 1'b0;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						ci_q    <= '0;
						state_q <= S_DIV_INIT;
					end
				end
				S_DIV_INIT: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(QT_W - 1)) begin
						if (ci_q == 2'd2) begin
							if (pass_q == PASS_Z) begin
								pass_q  <= PASS_UP;
								state_q <= S_SCALE_P;
							end else begin
								mode_q   <= MODE_CR2;
								gi_q     <= '0;
								ti_q     <= '0;
								issued_q <= 1'b0;
								state_q  <= S_MAC;
							end
						end else begin
							ci_q    <= ci_q + 2'd1;
							state_q <= S_DIV_INIT;
						end
					end
				end
				S_DONE: begin
					if (!sol_stall) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/lav_columns.sv @@
`timescale 1ns / 1ps
module lav_columns (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sol_valid,
	input  lav_pkg::solved_t sol,
	output logic             sol_stall,
	output logic             column_valid,
	input  logic             column_stall,
	output logic [1:0]       column_index,
	output lav_pkg::coord_t  entry_row0,
	output lav_pkg::coord_t  entry_row1,
	output lav_pkg::coord_t  entry_row2,
	output lav_pkg::coord_t  entry_row3,
	output logic             degenerate,
	output logic             last_column
);
	import lav_pkg::*;

	solved_t    mat_q;
	logic       full_q;
	logic [1:0] col_q;
	logic       adv;
	coord_t     r0_c;
	coord_t     r1_c;
	coord_t     r2_c;
	coord_t     r3_c;

	assign sol_stall = full_q;
	assign adv       = !column_valid || !column_stall;

	// Build the column under the counter
	always_comb begin
		if (col_q == 2'd3) begin
			r0_c = '0;
			r1_c = '0;
			r2_c = '0;
			r3_c = COORD_ONE;
		end else begin
			r0_c = COORD_W'(mat_q.ax[col_q][0]);
			r1_c = COORD_W'(mat_q.ax[col_q][1]);
			r2_c = COORD_W'(mat_q.ax[col_q][2]);
			r3_c = mat_q.trans[col_q];
		end
	end

	// Hold the matrix and the output column
	always_ff @(posedge clk) begin
		if (sol_valid && !full_q) mat_q <= sol;
		if (adv && full_q) begin
			column_index <= col_q;
			entry_row0   <= r0_c;
			entry_row1   <= r1_c;
			entry_row2   <= r2_c;
			entry_row3   <= r3_c;
			degenerate   <= mat_q.degen;
			last_column  <= (col_q == 2'd3);
		end
	end

	// Advance through four columns per matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q       <= 1'b0;
			col_q        <= '0;
			column_valid <= 1'b0;
		end else begin
			if (sol_valid && !full_q) begin
				full_q <= 1'b1;
				col_q  <= '0;
			end
			if (adv) begin
				column_valid <= full_q;
				if (full_q) begin
					col_q <= col_q + 2'd1;
					if (col_q == 2'd3) full_q <= 1'b0;
				end
			end
		end
	end

endmodule

@@ rtl/look_at_view_matrix_core.sv @@
// After a matrix is solved, the column stage sends its four columns at one column a cycle
// while column_stall is low.
// The solver takes one item at a time and runs its shared 32-step square root and 17-step
// divider for z and x, the divider once per component; degenerate vectors skip those steps.
// The input queue holds two items and the column stage holds one matrix while the next solves.
// Reset (arst_n low, asynchronous) empties the queue, idles the solver, drops column_valid.
`timescale 1ns / 1ps
module look_at_view_matrix_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  lav_pkg::coord_t eye_x,
	input  lav_pkg::coord_t eye_y,
	input  lav_pkg::coord_t eye_z,
	input  lav_pkg::coord_t target_x,
	input  lav_pkg::coord_t target_y,
	input  lav_pkg::coord_t target_z,
	input  lav_pkg::coord_t up_x,
	input  lav_pkg::coord_t up_y,
	input  lav_pkg::coord_t up_z,
	output logic            column_valid,
	input  logic            column_stall,
	output logic [1:0]      column_index,
	output lav_pkg::coord_t entry_row0,
	output lav_pkg::coord_t entry_row1,
	output lav_pkg::coord_t entry_row2,
	output lav_pkg::coord_t entry_row3,
	output logic            degenerate,
	output logic            last_column
);
	import lav_pkg::*;

	logic    q_valid;
	item_t   q_item;
	logic    q_pop;
	logic    sol_valid;
	solved_t sol;
	logic    sol_stall;

	lav_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.eye_x      (eye_x),
		.eye_y      (eye_y),
		.eye_z      (eye_z),
		.target_x   (target_x),
		.target_y   (target_y),
		.target_z   (target_z),
		.up_x       (up_x),
		.up_y       (up_y),
		.up_z       (up_z),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	lav_solver u_solver (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.sol_valid (sol_valid),
		.sol       (sol),
		.sol_stall (sol_stall)
	);

	lav_columns u_columns (
		.clk          (clk),
		.arst_n       (arst_n),
		.sol_valid    (sol_valid),
		.sol          (sol),
		.sol_stall    (sol_stall),
		.column_valid (column_valid),
		.column_stall (column_stall),
		.column_index (column_index),
		.entry_row0   (entry_row0),
		.entry_row1   (entry_row1),
		.entry_row2   (entry_row2),
		.entry_row3   (entry_row3),
		.degenerate   (degenerate),
		.last_column  (last_column)
	);

endmodule

@@ verif/tb_look_at_view_matrix_core.sv @@
`timescale 1ns / 1ps
module tb_look_at_view_matrix_core;
	import lav_pkg::*;

	typedef longint vec3_t [3];

	typedef struct {
		logic [1:0] index;
		coord_t     row0;
		coord_t     row1;
		coord_t     row2;
		coord_t     row3;
		logic       degen;
		logic       last;
	} column_t;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	coord_t eye_x, eye_y, eye_z;
	coord_t target_x, target_y, target_z;
	coord_t up_x, up_y, up_z;
	logic column_valid;
	logic column_stall;
	logic [1:0] column_index;
	coord_t entry_row0, entry_row1, entry_row2, entry_row3;
	logic degenerate;
	logic last_column;

	column_t expected_columns[$];
	int send_idle_pct;
	int recv_stall_pct;
	bit failed;

	look_at_view_matrix_core dut (.*);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop for a hung run
	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// Integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return v < 0 ? -v : v;
	endfunction

	// Shift the vector as a group so its largest magnitude tops out at bit 29
	function automatic bit group_scale(input vec3_t v, output vec3_t o);
		longint unsigned mx, m;
		int p;
		mx = 0;
		p = 0;
		for (int i = 0; i < 3; i++) if (magnitude(v[i]) > mx) mx = magnitude(v[i]);
		if (mx == 0) begin
			o = '{0, 0, 0};
			return 1'b0;
		end
		while (p < 63 && (mx >> (p + 1)) != 0) p++;
		for (int i = 0; i < 3; i++) begin
			m = magnitude(v[i]);
			m = p > SCALE_TOP ? m >> (p - SCALE_TOP) : m << (SCALE_TOP - p);
			o[i] = v[i] < 0 ? -longint'(m) : longint'(m);
		end
		return 1'b1;
	endfunction

	function automatic bit unit_vector(input vec3_t v, output vec3_t u);
		vec3_t w;
		longint unsigned sum, len, q;
		sum = 0;
		if (!group_scale(v, w)) begin
			u = '{0, 0, 0};
			return 1'b0;
		end
		for (int i = 0; i < 3; i++) sum += magnitude(w[i]) * magnitude(w[i]);
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((magnitude(w[i]) << FRAC_W) + len / 2) / len;
			u[i] = w[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic vec3_t cross_product(vec3_t a, vec3_t b);
		vec3_t c;
		c[0] = a[1] * b[2] - a[2] * b[1];
		c[1] = a[2] * b[0] - a[0] * b[2];
		c[2] = a[0] * b[1] - a[1] * b[0];
		return c;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > COORD_MAX) return coord_t'(COORD_MAX);
		if (v < COORD_MIN) return coord_t'(COORD_MIN);
		return coord_t'(v);
	endfunction

	// Round half up: floor(v / 2^F + 1/2)
	function automatic longint round_frac(longint v);
		return (v + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
	endfunction

	// Build the four view-matrix columns for one item and queue them
	task automatic predict_view_matrix(vec3_t eye, vec3_t tgt, vec3_t up);
		vec3_t d, z, ups, c, x, zr, y;
		vec3_t axes [3];
		longint dot;
		bit degen;
		column_t col;
		degen = 1'b0;
		for (int i = 0; i < 3; i++) d[i] = eye[i] - tgt[i];
		if (!unit_vector(d, z)) degen = 1'b1;
		void'(group_scale(up, ups));
		c = cross_product(ups, z);
		if (!unit_vector(c, x)) degen = 1'b1;
		zr = cross_product(z, x);
		for (int i = 0; i < 3; i++) y[i] = round_frac(zr[i]);
		axes[0] = x;
		axes[1] = y;
		axes[2] = z;
		for (int j = 0; j < 3; j++) begin
			dot = 0;
			for (int i = 0; i < 3; i++) dot += eye[i] * axes[j][i];
			col.index = 2'(j);
			col.row0  = clamp_coord(axes[j][0]);
			col.row1  = clamp_coord(axes[j][1]);
			col.row2  = clamp_coord(axes[j][2]);
			col.row3  = clamp_coord(round_frac(-dot));
			col.degen = degen;
			col.last  = 1'b0;
			expected_columns.push_back(col);
		end
		col.index = 2'd3;
		col.row0  = '0;
		col.row1  = '0;
		col.row2  = '0;
		col.row3  = clamp_coord(64'sd1 <<< FRAC_W);
		col.degen = degen;
		col.last  = 1'b1;
		expected_columns.push_back(col);
	endtask

	// Drive one item and hold it until the transfer completes
	task automatic send_item(coord_t ex, coord_t ey, coord_t ez, coord_t tx, coord_t ty,
			coord_t tz, coord_t ux, coord_t uy, coord_t uz);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid = 1'b0;
			@(negedge clk);
		end
		eye_x = ex; eye_y = ey; eye_z = ez;
		target_x = tx; target_y = ty; target_z = tz;
		up_x = ux; up_y = uy; up_z = uz;
		item_valid = 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		predict_view_matrix('{ex, ey, ez}, '{tx, ty, tz}, '{ux, uy, uz});
		@(negedge clk);
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(3))
			0: return coord_t'($urandom);
			1: return coord_t'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
			2: return coord_t'($signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000);
			default: return coord_t'($signed($urandom_range(8)) - 4);
		endcase
	endfunction

	// Randomly stall the column channel
	always @(negedge clk) begin
		column_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Compare each column transfer with the oldest prediction
	always @(posedge clk) begin
		column_t e;
		if (arst_n && column_valid && !column_stall) begin
			if (expected_columns.size() == 0) begin
				$error("unexpected column index=%0d", column_index);
				failed = 1'b1;
			end else begin
				e = expected_columns.pop_front();
				if (column_index !== e.index) begin
					$error("column_index: expected %0d, got %0d", e.index, column_index);
					failed = 1'b1;
				end
				if (entry_row0 !== e.row0) begin
					$error("entry_row0: expected %0d, got %0d", e.row0, entry_row0);
					failed = 1'b1;
				end
				if (entry_row1 !== e.row1) begin
					$error("entry_row1: expected %0d, got %0d", e.row1, entry_row1);
					failed = 1'b1;
				end
				if (entry_row2 !== e.row2) begin
					$error("entry_row2: expected %0d, got %0d", e.row2, entry_row2);
					failed = 1'b1;
				end
				if (entry_row3 !== e.row3) begin
					$error("entry_row3: expected %0d, got %0d", e.row3, entry_row3);
					failed = 1'b1;
				end
				if (degenerate !== e.degen) begin
					$error("degenerate: expected %0d, got %0d", e.degen, degenerate);
					failed = 1'b1;
				end
				if (last_column !== e.last) begin
					$error("last_column: expected %0d, got %0d", e.last, last_column);
					failed = 1'b1;
				end
			end
		end
	end

	task automatic test_extremes();
		coord_t mx, mn, one;
		mx = coord_t'(COORD_MAX);
		mn = coord_t'(COORD_MIN);
		one = COORD_ONE;
		// standard camera
		send_item(0, 0, 5 * one, 0, 0, 0, 0, one, 0);
		send_item(one, 2 * one, 3 * one, -one, 0, one, 0, 0, one);
		// widest difference and saturating translations
		send_item(mx, mx, mx, mn, mn, mn, mn, mx, 0);
		send_item(mn, mn, mn, mx, mx, mx, mx, mn, mx);
		send_item(mx, mx, mx, 0, 0, 0, 0, one, 0);
		send_item(mn, mn, mn, 0, 0, 0, 0, 0, one);
		send_item(mx, mn, mx, mn, mx, mn, mx, mx, mn);
		send_item(mn, 0, mx, 0, mx, mn, mn, mn, mn);
		send_item(1, -1, 1, 0, 0, 0, 1, 1, -1);
		send_item(-1, -1, -1, 1, 1, 1, 32'h5555_5555, 32'haaaa_aaaa, 1);
	endtask

	task automatic test_degenerate();
		coord_t one;
		one = COORD_ONE;
		// eye equals target
		send_item(one, one, one, one, one, one, 0, one, 0);
		send_item(coord_t'(COORD_MAX), 0, 0, coord_t'(COORD_MAX), 0, 0, 0, 0, 0);
		// up zero
		send_item(0, 0, one, 0, 0, 0, 0, 0, 0);
		// up parallel to z, either direction
		send_item(0, 0, one, 0, 0, 0, 0, 0, 7 * one);
		send_item(3, 3, 3, 0, 0, 0, -5, -5, -5);
		send_item(0, 4 * one, 0, 0, 0, 0, 0, coord_t'(COORD_MIN), 0);
		// everything zero
		send_item(0, 0, 0, 0, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random(int count, int idle_pct, int stall_pct);
		coord_t e[3], t[3], u[3];
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) begin
			for (int i = 0; i < 3; i++) begin
				e[i] = rand_coord();
				t[i] = rand_coord();
				u[i] = rand_coord();
			end
			// occasionally force a degenerate shape
			case ($urandom_range(9))
				0: t = e;
				1: u = '{0, 0, 0};
				2: for (int i = 0; i < 3; i++) u[i] = e[i] - t[i];
				default: ;
			endcase
			send_item(e[0], e[1], e[2], t[0], t[1], t[2], u[0], u[1], u[2]);
		end
		item_valid = 1'b0;
	endtask

	initial begin
		failed = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		column_stall = 1'b0;
		eye_x = '0; eye_y = '0; eye_z = '0;
		target_x = '0; target_y = '0; target_z = '0;
		up_x = '0; up_y = '0; up_z = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_extremes();
		test_degenerate();
		test_random(34, 0, 0);
		test_random(34, 55, 0);
		test_random(34, 0, 55);
		test_random(34, 33, 33);

		// drain outstanding columns, then let the pipeline settle
		while (expected_columns.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (!failed && expected_columns.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
